@@ rtl/lgpsr_pkg.sv @@
`default_nettype none
package lgpsr_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_EXCHANGE = 2'd0;
  localparam logic [1:0] OP_BUTTON   = 2'd1;
  localparam logic [1:0] OP_DESELECT = 2'd2;

  // button codes
  localparam logic [1:0] BTN_TRIGGER  = 2'd0;
  localparam logic [1:0] BTN_A        = 2'd1;
  localparam logic [1:0] BTN_B        = 2'd2;
  localparam logic [1:0] BTN_SHOOT_OS = 2'd3;

  // button bit positions in the active-low button word
  localparam logic [3:0] BIT_TRIGGER = 4'd13;
  localparam logic [3:0] BIT_A       = 4'd3;
  localparam logic [3:0] BIT_B       = 4'd14;

  // protocol bytes
  localparam logic [15:0] PAD_ID     = 16'h5A63;
  localparam logic [7:0]  CMD_SELECT = 8'h01;
  localparam logic [7:0]  CMD_READ   = 8'h42;
  localparam logic [7:0]  IDLE_REPLY = 8'hFF;
  localparam logic [15:0] OFF_X      = 16'h0001;
  localparam logic [15:0] OFF_Y      = 16'h000A;

  // configuration register map
  localparam int unsigned   PADDR_W        = 3;
  localparam logic          REG_TICK_SCALE = 1'b0;
  localparam logic [15:0]   TICK_SCALE_RST = 16'd9851;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_in;
    logic [1:0]  btn_sel;
    logic        pressed;
    logic        aim_valid;
    logic [11:0] beam_tick;
    logic [8:0]  beam_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       ack;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/lgpsr_apb.sv @@
`default_nettype none
module lgpsr_apb
  import lgpsr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output logic      [15:0]        tick_scale_o
);

  logic [15:0] scale_q;
  logic        sel_scale;

  // register decode on the word address bit
  assign sel_scale = (paddr[PADDR_W-1] == REG_TICK_SCALE);
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= TICK_SCALE_RST;
    end else if (psel && penable && pwrite && pready && sel_scale) begin
      scale_q <= pwdata[15:0];
    end
  end

  // read back
  assign prdata       = sel_scale ? {16'b0, scale_q} : 32'b0;
  assign tick_scale_o = scale_q;

endmodule
`default_nettype wire

@@ rtl/lgpsr_engine.sv @@
`default_nettype none
module lgpsr_engine
  import lgpsr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire in_item_t    item_i,
  input  wire logic [15:0] tick_scale_i,
  output logic             has_res_o,
  output out_item_t        res_o
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_READY = 4'd1,
    PH_IDHI  = 4'd2,
    PH_BTNLO = 4'd3,
    PH_BTNHI = 4'd4,
    PH_XLO   = 4'd5,
    PH_XHI   = 4'd6,
    PH_YLO   = 4'd7,
    PH_YHI   = 4'd8
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] buttons_q, buttons_d;
  logic        offscr_q, offscr_d;
  logic [15:0] aim_x_q, aim_x_d;
  logic [15:0] aim_y_q, aim_y_d;
  logic [27:0] prod;
  logic [3:0]  btn_bit;
  logic [15:0] btn_mask;
  logic        btn_down;
  logic        btn_apply;

  // beam ticks scaled to 8 MHz units
  assign prod = {16'b0, item_i.beam_tick} * {12'b0, tick_scale_i};

  // which bit a button event touches
  always_comb begin
    btn_bit   = BIT_TRIGGER;
    btn_apply = 1'b1;
    case (item_i.btn_sel)
      BTN_A:        btn_bit = BIT_A;
      BTN_B:        btn_bit = BIT_B;
      BTN_SHOOT_OS: btn_apply = (item_i.pressed != offscr_q);
      default:      btn_bit = BIT_TRIGGER;
    endcase
  end

  assign btn_mask = 16'(16'd1 << btn_bit);
  assign btn_down = item_i.pressed;

  assign has_res_o = (item_i.operation == OP_EXCHANGE);

  // next state and reply byte
  always_comb begin
    phase_d   = phase_q;
    buttons_d = buttons_q;
    offscr_d  = offscr_q;
    aim_x_d   = aim_x_q;
    aim_y_d   = aim_y_q;
    res_o.reply_byte = IDLE_REPLY;
    res_o.ack        = 1'b0;
    case (item_i.operation)
      OP_BUTTON: begin
        if (btn_apply) begin
          buttons_d = btn_down ? (buttons_q & ~btn_mask) : (buttons_q | btn_mask);
          if (item_i.btn_sel == BTN_SHOOT_OS) begin
            offscr_d = btn_down;
          end
        end
      end
      OP_DESELECT: phase_d = PH_IDLE;
      OP_EXCHANGE: begin
        unique case (phase_q)
          PH_READY: begin
            if (item_i.data_in == CMD_READ) begin
              res_o.reply_byte = PAD_ID[7:0];
              res_o.ack        = 1'b1;
              phase_d          = PH_IDHI;
            end
          end
          PH_IDHI: begin
            res_o.reply_byte = PAD_ID[15:8];
            res_o.ack        = 1'b1;
            phase_d          = PH_BTNLO;
          end
          PH_BTNLO: begin
            res_o.reply_byte = buttons_q[7:0];
            res_o.ack        = 1'b1;
            phase_d          = PH_BTNHI;
          end
          PH_BTNHI: begin
            res_o.reply_byte = buttons_q[15:8];
            res_o.ack        = 1'b1;
            phase_d          = PH_XLO;
          end
          PH_XLO: begin
            // latch the aim point here
            if (!item_i.aim_valid || offscr_q) begin
              aim_x_d = OFF_X;
              aim_y_d = OFF_Y;
            end else begin
              aim_x_d = {4'b0, prod[27:16]};
              aim_y_d = {7'b0, item_i.beam_line};
            end
            res_o.reply_byte = aim_x_d[7:0];
            res_o.ack        = 1'b1;
            phase_d          = PH_XHI;
          end
          PH_XHI: begin
            res_o.reply_byte = aim_x_q[15:8];
            res_o.ack        = 1'b1;
            phase_d          = PH_YLO;
          end
          PH_YLO: begin
            res_o.reply_byte = aim_y_q[7:0];
            res_o.ack        = 1'b1;
            phase_d          = PH_YHI;
          end
          PH_YHI: begin
            res_o.reply_byte = aim_y_q[15:8];
            phase_d          = PH_IDLE;
          end
          default: begin
            if (item_i.data_in == CMD_SELECT) begin
              res_o.ack = 1'b1;
              phase_d   = PH_READY;
            end else begin
              phase_d   = PH_IDLE;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  // pad state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      buttons_q <= 16'hFFFF;
      offscr_q  <= 1'b0;
      aim_x_q   <= 16'h0000;
      aim_y_q   <= 16'h0000;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      buttons_q <= buttons_d;
      offscr_q  <= offscr_d;
      aim_x_q   <= aim_x_d;
      aim_y_q   <= aim_y_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lightgun_pad_serial_responder_top.sv @@
`default_nettype none
// Light-gun pad responder for a byte-serial controller port. Each item is a
// serial byte exchange, a button event or a port deselect; only an exchange
// gives a result item (reply byte and acknowledge). An accepted item is held
// in an input register, where the phase logic and the 12x16 aim multiply act
// on it, and its result lands in an output register. One item is taken every
// cycle while results are drained; a stalled result holds back only the items
// behind it. The tick scale register sits at byte address 0 of the APB port
// and should be written while no items are in flight.
module lightgun_pad_serial_responder_top
  import lgpsr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_item_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  logic        in_vld_q;
  in_item_t    in_q;
  logic        out_vld_q;
  out_item_t   out_q;
  logic        stg_fire;
  logic        has_res;
  out_item_t   res;
  logic [15:0] tick_scale;

  lgpsr_apb u_apb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .tick_scale_o (tick_scale)
  );

  lgpsr_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (stg_fire),
    .item_i       (in_q),
    .tick_scale_i (tick_scale),
    .has_res_o    (has_res),
    .res_o        (res)
  );

  // the held item moves on unless its result would overwrite a waiting one
  assign stg_fire   = in_vld_q && (!has_res || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || stg_fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (stg_fire && has_res) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_fire && has_res) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // a result never overwrites one the consumer has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_fire && has_res |-> !out_vld_q || out_ready_i)
    else $error("result register overrun");

  // a new result only comes from the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(stg_fire) && $past(has_res))
    else $error("result without a processed item");

  // backpressure at the input only with an item held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && has_res && out_vld_q)
    else $error("input stalled without cause");
`endif

endmodule
`default_nettype wire
